/* rtl/smsab_pkg.sv */
// ----------------------------------------------------------------------------
// smsab_pkg
// shared constants and types for the signed shift-add / booth multiplier
// ----------------------------------------------------------------------------
package smsab_pkg;

  // default operand and product widths
  localparam int DEF_OPERAND_BITS = 8;
  localparam int DEF_PRODUCT_BITS = 15;

  // product format selector
  localparam logic KIND_SIGN_MAG = 1'b0;
  localparam logic KIND_BOOTH    = 1'b1;

  // control bits that ride along with every beat in the cell chain
  typedef struct packed {
    logic valid;
    logic kind;
    logic neg;
    logic oor;
  } stage_ctl_t;

endpackage

/* rtl/smsab_req_if.sv */
// ----------------------------------------------------------------------------
// smsab_req_if
// operand channel: kind selector and two signed operands
// ----------------------------------------------------------------------------
interface smsab_req_if #(
  parameter int OPERAND_BITS = smsab_pkg::DEF_OPERAND_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [OPERAND_BITS-1:0] multiplicand;
  logic signed [OPERAND_BITS-1:0] multiplier;

  modport source (output valid, output kind, output multiplicand, output multiplier,
                  input ready);
  modport sink   (input valid, input kind, input multiplicand, input multiplier,
                  output ready);
endinterface

/* rtl/smsab_rsp_if.sv */
// ----------------------------------------------------------------------------
// smsab_rsp_if
// result channel: product word and out-of-range flag
// ----------------------------------------------------------------------------
interface smsab_rsp_if #(
  parameter int PRODUCT_BITS = smsab_pkg::DEF_PRODUCT_BITS
);
  logic                    valid;
  logic                    ready;
  logic [PRODUCT_BITS-1:0] product_word;
  logic                    out_of_range;

  modport source (output valid, output product_word, output out_of_range, input ready);
  modport sink   (input valid, input product_word, input out_of_range, output ready);
endinterface

/* rtl/signed_multiplier_shift_add_and_booth_unit.sv */
// ----------------------------------------------------------------------------
// signed_multiplier_shift_add_and_booth_unit
// signed multiplier with sign-magnitude and two's complement product formats
// ----------------------------------------------------------------------------
// Takes one operand beat per cycle and returns one product beat per operand
// beat, in order. The pipe is an input stage, a chain of OPERAND_BITS cells
// that each handle one multiplier bit with a single PRODUCT_BITS-wide
// add/subtract, and an output register. A stall on the result side freezes
// the whole chain; otherwise a new beat enters every cycle. Kind 0 gives the
// sign in the top bit over the magnitude product; kind 1 gives the radix-2
// booth two's complement product. An operand equal to the most negative code
// sets out_of_range and forces a zero product word.
module signed_multiplier_shift_add_and_booth_unit #(
  parameter int OPERAND_BITS = smsab_pkg::DEF_OPERAND_BITS,
  parameter int PRODUCT_BITS = smsab_pkg::DEF_PRODUCT_BITS
) (
  input logic         clk,
  input logic         rst,
  smsab_req_if.sink   req,
  smsab_rsp_if.source rsp
);
  import smsab_pkg::*;

  stage_ctl_t              ctl_chain  [0:OPERAND_BITS];
  logic [PRODUCT_BITS-1:0] base_chain [0:OPERAND_BITS];
  logic [OPERAND_BITS-1:0] mult_chain [0:OPERAND_BITS];
  logic [PRODUCT_BITS-1:0] acc_chain  [0:OPERAND_BITS];
  logic                    adv;
  stage_ctl_t              last_ctl;
  logic [PRODUCT_BITS-1:0] last_acc;
  logic [PRODUCT_BITS-1:0] word_next;

  // whole pipe moves unless a finished beat is held at the output
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // input stage
  smsab_prep #(
    .OPERAND_BITS (OPERAND_BITS),
    .PRODUCT_BITS (PRODUCT_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_a     (req.multiplicand),
    .in_b     (req.multiplier),
    .ctl      (ctl_chain[0]),
    .base     (base_chain[0]),
    .mult     (mult_chain[0])
  );

  assign acc_chain[0] = '0;

  // one cell per multiplier bit
  for (genvar i = 0; i < OPERAND_BITS; i++) begin : g_cell
    smsab_cell #(
      .OPERAND_BITS (OPERAND_BITS),
      .PRODUCT_BITS (PRODUCT_BITS),
      .BIT_POS      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_in   (ctl_chain[i]),
      .base_in  (base_chain[i]),
      .mult_in  (mult_chain[i]),
      .acc_in   (acc_chain[i]),
      .ctl_out  (ctl_chain[i+1]),
      .base_out (base_chain[i+1]),
      .mult_out (mult_chain[i+1]),
      .acc_out  (acc_chain[i+1])
    );
  end

  // product word formatting
  assign last_ctl = ctl_chain[OPERAND_BITS];
  assign last_acc = acc_chain[OPERAND_BITS];

  always_comb begin
    if (last_ctl.oor) begin
      word_next = '0;
    end else if (last_ctl.kind == KIND_BOOTH) begin
      word_next = last_acc;
    end else begin
      word_next = {last_ctl.neg, last_acc[PRODUCT_BITS-2:0]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.product_word <= word_next;
      rsp.out_of_range <= last_ctl.oor;
    end
  end

endmodule

/* rtl/smsab_prep.sv */
// ----------------------------------------------------------------------------
// smsab_prep
// input stage: operand magnitudes, addend base, sign and range flags
// ----------------------------------------------------------------------------
module smsab_prep #(
  parameter int OPERAND_BITS = smsab_pkg::DEF_OPERAND_BITS,
  parameter int PRODUCT_BITS = smsab_pkg::DEF_PRODUCT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic                    in_kind,
  input  logic [OPERAND_BITS-1:0] in_a,
  input  logic [OPERAND_BITS-1:0] in_b,
  output smsab_pkg::stage_ctl_t   ctl,
  output logic [PRODUCT_BITS-1:0] base,
  output logic [OPERAND_BITS-1:0] mult
);
  import smsab_pkg::*;

  localparam int EXT = (OPERAND_BITS > PRODUCT_BITS) ? OPERAND_BITS : PRODUCT_BITS;

  logic [OPERAND_BITS-1:0] mag_a;
  logic [OPERAND_BITS-1:0] mag_b;
  logic [EXT-1:0]          a_sext;
  logic [EXT-1:0]          a_zext;
  logic                    sign_a;
  logic                    sign_b;
  logic                    min_a;
  logic                    min_b;
  stage_ctl_t              ctl_next;
  logic [PRODUCT_BITS-1:0] base_next;
  logic [OPERAND_BITS-1:0] mult_next;

  // magnitudes and extensions
  always_comb begin
    sign_a = in_a[OPERAND_BITS-1];
    sign_b = in_b[OPERAND_BITS-1];
    mag_a  = sign_a ? (~in_a + 1'b1) : in_a;
    mag_b  = sign_b ? (~in_b + 1'b1) : in_b;
    a_sext = EXT'(signed'(in_a));
    a_zext = EXT'(mag_a);
    min_a  = sign_a && (in_a[OPERAND_BITS-2:0] == '0);
    min_b  = sign_b && (in_b[OPERAND_BITS-2:0] == '0);
  end

  // per-kind addend base and scanned multiplier
  always_comb begin
    ctl_next.valid = in_valid;
    ctl_next.kind  = in_kind;
    ctl_next.oor   = min_a || min_b;
    ctl_next.neg   = (mag_a != '0) && (mag_b != '0) && (sign_a ^ sign_b);
    if (in_kind == KIND_BOOTH) begin
      base_next = a_sext[PRODUCT_BITS-1:0];
      mult_next = in_b;
    end else begin
      base_next = a_zext[PRODUCT_BITS-1:0];
      mult_next = mag_b;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl.valid <= ctl_next.valid;
    end
    if (adv) begin
      ctl.kind <= ctl_next.kind;
      ctl.neg  <= ctl_next.neg;
      ctl.oor  <= ctl_next.oor;
      base     <= base_next;
      mult     <= mult_next;
    end
  end

endmodule

/* rtl/smsab_cell.sv */
// ----------------------------------------------------------------------------
// smsab_cell
// one multiplier bit: adds, subtracts or skips the shifted base
// ----------------------------------------------------------------------------
module smsab_cell #(
  parameter int OPERAND_BITS = smsab_pkg::DEF_OPERAND_BITS,
  parameter int PRODUCT_BITS = smsab_pkg::DEF_PRODUCT_BITS,
  parameter int BIT_POS      = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  smsab_pkg::stage_ctl_t   ctl_in,
  input  logic [PRODUCT_BITS-1:0] base_in,
  input  logic [OPERAND_BITS-1:0] mult_in,
  input  logic [PRODUCT_BITS-1:0] acc_in,
  output smsab_pkg::stage_ctl_t   ctl_out,
  output logic [PRODUCT_BITS-1:0] base_out,
  output logic [OPERAND_BITS-1:0] mult_out,
  output logic [PRODUCT_BITS-1:0] acc_out
);
  import smsab_pkg::*;

  logic [OPERAND_BITS:0]   mult_pad;
  logic                    cur_bit;
  logic                    prev_bit;
  logic [PRODUCT_BITS-1:0] term;
  logic [PRODUCT_BITS-1:0] acc_next;

  // scan bit and its lower neighbor (zero below bit 0)
  assign mult_pad = {mult_in, 1'b0};
  assign cur_bit  = mult_pad[BIT_POS+1];
  assign prev_bit = mult_pad[BIT_POS];
  assign term     = base_in << BIT_POS;

  // shift-add adds on a one; booth subtracts at the start of a run of ones and adds after its end
  always_comb begin
    acc_next = acc_in;
    if (ctl_in.kind == KIND_BOOTH) begin
      if (cur_bit && !prev_bit) begin
        acc_next = acc_in - term;
      end else if (!cur_bit && prev_bit) begin
        acc_next = acc_in + term;
      end
    end else if (cur_bit) begin
      acc_next = acc_in + term;
    end
  end

  // hand the beat to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (adv) begin
      ctl_out.kind <= ctl_in.kind;
      ctl_out.neg  <= ctl_in.neg;
      ctl_out.oor  <= ctl_in.oor;
      base_out     <= base_in;
      mult_out     <= mult_in;
      acc_out      <= acc_next;
    end
  end

endmodule
